// File: design/kte_pkg.sv
// ----------------------------------------------------------------------------
// kte_pkg
// Shared types and constants of the keyed tag field extractor.
// ----------------------------------------------------------------------------
package kte_pkg;

  localparam int KEY_BYTES   = 16;
  localparam int MAX_CAPTURE = 99;
  localparam int Q_DEPTH     = 4;

  localparam int FILL_W  = $clog2(KEY_BYTES + 1);
  localparam int IDX_W   = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int CAP_W   = 7;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_NL = 8'h0A;

  // configuration register indexes
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;
  localparam logic [1:0] REG_TAG_CNT  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       found;
  } out_t;

  typedef struct packed {
    logic push;
    out_t data;
  } push_t;

endpackage

// File: design/kte_scan.sv
// ----------------------------------------------------------------------------
// kte_scan
// Front end: key search window, tag counting and field capture; emits at most
// one result per accepted byte toward the queue.
// ----------------------------------------------------------------------------
module kte_scan import kte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        accept,
  input  in_t         in_data,
  output push_t       res
);

  localparam logic [1:0] PH_SEARCH  = 2'd0;
  localparam logic [1:0] PH_COUNT   = 2'd1;
  localparam logic [1:0] PH_CAPTURE = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  logic [63:0]      key_low;
  logic [63:0]      key_high;
  logic [4:0]       key_len;
  logic [7:0]       tag_cnt;

  logic [7:0]       window [KEY_BYTES];
  logic [7:0]       window_next [KEY_BYTES];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic [1:0]       phase;
  logic [1:0]       phase_next;
  logic [7:0]       tags;
  logic [7:0]       tags_next;
  logic [7:0]       tags_inc;
  logic [CAP_W-1:0] cap;
  logic [CAP_W-1:0] cap_next;

  logic [127:0]      key_all;
  logic [FILL_W-1:0] key_n;
  logic              mismatch;
  logic              match;
  logic              emit;
  logic              success;
  logic [7:0]        b;
  logic              eos;

  assign b       = in_data.data_byte;
  assign eos     = in_data.end_of_stream;
  assign key_all = {key_high, key_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      key_len  <= 5'd1;
      tag_cnt  <= 8'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KEY_LOW:  key_low  <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LEN:  key_len  <= cfg_data[4:0];
        REG_TAG_CNT:  tag_cnt  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // effective key length, clamped to 1..KEY_BYTES
  always_comb begin
    if (key_len == 5'd0) begin
      key_n = FILL_W'(1);
    end else if (key_len > 5'(KEY_BYTES)) begin
      key_n = FILL_W'(KEY_BYTES);
    end else begin
      key_n = FILL_W'(key_len);
    end
  end

  always_comb begin
    window_next[0] = b;
    for (int j = 1; j < KEY_BYTES; j++) begin
      window_next[j] = window[j-1];
    end
  end

  assign fill_next = (fill < FILL_W'(KEY_BYTES)) ? fill + FILL_W'(1) : fill;

  // key byte i sits at window position n-1-i (position 0 is the newest byte)
  always_comb begin
    mismatch = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (FILL_W'(i) < key_n) begin
        if (window_next[IDX_W'(key_n - FILL_W'(1) - FILL_W'(i))] != key_all[8*i +: 8]) begin
          mismatch = 1'b1;
        end
      end
    end
  end

  assign match    = (fill_next >= key_n) && !mismatch;
  assign tags_inc = (tags != 8'hFF) ? tags + 8'd1 : tags;

  always_comb begin
    phase_next = phase;
    tags_next  = tags;
    cap_next   = cap;
    emit       = 1'b0;
    success    = 1'b0;
    unique case (phase)
      PH_SEARCH: begin
        if (match) begin
          phase_next = PH_COUNT;
          tags_next  = 8'd0;
        end
      end
      PH_COUNT: begin
        if (b == CH_GT) begin
          tags_next = tags_inc;
          if (tags_inc == tag_cnt) begin
            phase_next = PH_CAPTURE;
            cap_next   = '0;
          end
        end
      end
      PH_CAPTURE: begin
        if (cap == '0) begin
          emit     = 1'b1;
          cap_next = CAP_W'(1);
        end else if (b == CH_LT) begin
          success    = 1'b1;
          phase_next = PH_DONE;
        end else if (cap < CAP_W'(MAX_CAPTURE)) begin
          emit     = 1'b1;
          cap_next = cap + CAP_W'(1);
        end
      end
      default: ;
    endcase
  end

  // success wins over end of stream; a finished stream ends silently
  always_comb begin
    res = '0;
    if (success) begin
      res.push          = accept;
      res.data.out_byte = CH_NL;
      res.data.last     = 1'b1;
      res.data.found    = 1'b1;
    end else if (eos) begin
      res.push          = accept && (phase != PH_DONE);
      res.data.last     = 1'b1;
    end else if (emit) begin
      res.push          = accept;
      res.data.out_byte = b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      phase <= PH_SEARCH;
      tags  <= '0;
      cap   <= '0;
    end else if (accept) begin
      if (eos) begin
        fill  <= '0;
        phase <= PH_SEARCH;
        tags  <= '0;
        cap   <= '0;
      end else begin
        if (phase == PH_SEARCH) begin
          fill <= fill_next;
        end
        phase <= phase_next;
        tags  <= tags_next;
        cap   <= cap_next;
      end
    end
  end

  // window bytes beyond fill are never compared, so no reset needed
  always_ff @(posedge clk) begin
    if (accept && (phase == PH_SEARCH)) begin
      for (int j = 0; j < KEY_BYTES; j++) begin
        window[j] <= window_next[j];
      end
    end
  end

endmodule

// File: design/kte_queue.sv
// ----------------------------------------------------------------------------
// kte_queue
// Back end: short result queue that drives the output channel, so the
// scanner and the consumer stall independently.
// ----------------------------------------------------------------------------
module kte_queue import kte_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t res,
  output logic  full,
  output logic  out_valid,
  input  logic  out_stall,
  output out_t  out_data
);

  out_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               pop;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (res.push) begin
      entries[wr_ptr] <= res.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res.push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (res.push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !res.push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

endmodule

// File: design/keyed_tag_field_extractor.sv
// ----------------------------------------------------------------------------
// keyed_tag_field_extractor
// Finds a key in a byte stream, skips to the n-th '>' after it and returns the
// field bytes up to the next '<', closed by a newline marked last and found.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the input is not stalled; the key compare
// over the 16-byte window, tag counting and capture decisions all finish in
// the accepting cycle. Each result is registered into a 4-entry queue that
// drives the output. Input stalls only while that queue is full, so with the
// output never stalled the block sustains one byte per clock. Configuration is
// written through cfg_write/cfg_index/cfg_data while the block is idle.
module keyed_tag_field_extractor import kte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  push_t res;
  logic  full;
  logic  accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  kte_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_data   (in_data),
    .res       (res)
  );

  kte_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_found_is_newline: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |-> out_data.last && (out_data.out_byte == CH_NL))
    else $error("found result without closing newline");

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last && !out_data.found |-> (out_data.out_byte == 8'h00))
    else $error("not-found result with nonzero byte");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    res.push && !out_valid |=> out_valid)
    else $error("queued result not presented");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !res.push)
    else $error("push into full queue");
`endif

endmodule

// File: tb/kte_extract_checker.sv
// ----------------------------------------------------------------------------
// kte_extract_checker
// Watches the configuration port and both channels of the keyed tag field
// extractor, predicts every result from the accepted bytes and compares each
// output transfer field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module kte_extract_checker import kte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_t        out_data,
  output int          mismatches,
  output int          outstanding
);

  typedef enum logic [1:0] {SEEK_KEY, COUNT_TAGS, CAPTURE, FIELD_DONE} scan_phase_t;

  // shadow copy of the registers
  logic [63:0] key_lo, key_hi;
  logic [4:0]  key_len;
  logic [7:0]  tag_target;

  // shadow copy of the stream state
  logic [7:0]  win [KEY_BYTES];
  int          win_fill;
  scan_phase_t scan_phase;
  int          gt_seen;
  int          field_len;

  out_t        pending_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report(input string what, input int want_v, input int got_v);
    $display("MISMATCH %s: expected %0h, got %0h (t=%0t)", what, want_v, got_v, $time);
    mismatches++;
  endtask

  task automatic clear_stream();
    foreach (win[i]) win[i] = 8'h00;
    win_fill   = 0;
    scan_phase = SEEK_KEY;
    gt_seen    = 0;
    field_len  = 0;
  endtask

  function automatic bit key_in_window();
    int         n;
    logic [7:0] kb;
    bit         hit;
    n = (key_len == 0) ? 1 : (key_len > KEY_BYTES) ? KEY_BYTES : int'(key_len);
    if (win_fill < n) return 1'b0;
    hit = 1'b1;
    for (int i = 0; i < n; i++) begin
      kb = (i < 8) ? key_lo[i*8 +: 8] : key_hi[(i-8)*8 +: 8];
      // window entry 0 holds the newest byte, key byte 0 came first
      if (win[n-1-i] != kb) hit = 1'b0;
    end
    return hit;
  endfunction

  task automatic extract_step(input in_t item);
    logic [7:0] b;
    logic [7:0] ob;
    bit         eos, emit, success, was_done;
    out_t       r;
    b        = item.data_byte;
    eos      = item.end_of_stream;
    emit     = 1'b0;
    success  = 1'b0;
    was_done = (scan_phase == FIELD_DONE);
    ob       = 8'h00;
    case (scan_phase)
      SEEK_KEY: begin
        for (int i = KEY_BYTES - 1; i > 0; i--) win[i] = win[i-1];
        win[0] = b;
        if (win_fill < KEY_BYTES) win_fill++;
        if (key_in_window()) begin
          scan_phase = COUNT_TAGS;
          gt_seen    = 0;
        end
      end
      COUNT_TAGS: begin
        if (b == CH_GT) begin
          if (gt_seen < 255) gt_seen++;
          if (gt_seen == tag_target) begin
            scan_phase = CAPTURE;
            field_len  = 0;
          end
        end
      end
      CAPTURE: begin
        // first field byte goes out even if it is '<'
        if (field_len == 0) begin
          emit      = 1'b1;
          ob        = b;
          field_len = 1;
        end else if (b == CH_LT) begin
          success    = 1'b1;
          scan_phase = FIELD_DONE;
        end else if (field_len < MAX_CAPTURE) begin
          emit = 1'b1;
          ob   = b;
          field_len++;
        end
      end
      default: ;
    endcase

    if (success) begin
      r.out_byte = CH_NL;
      r.last     = 1'b1;
      r.found    = 1'b1;
      pending_results.push_back(r);
      if (eos) clear_stream();
    end else if (eos) begin
      clear_stream();
      if (!was_done) begin
        r.out_byte = 8'h00;
        r.last     = 1'b1;
        r.found    = 1'b0;
        pending_results.push_back(r);
      end
    end else if (emit) begin
      r.out_byte = ob;
      r.last     = 1'b0;
      r.found    = 1'b0;
      pending_results.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      key_lo     = '0;
      key_hi     = '0;
      key_len    = 5'd1;
      tag_target = 8'd1;
      clear_stream();
      pending_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_KEY_LOW:  key_lo     = cfg_data;
          REG_KEY_HIGH: key_hi     = cfg_data;
          REG_KEY_LEN:  key_len    = cfg_data[4:0];
          REG_TAG_CNT:  tag_target = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) extract_step(in_data);
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report("unexpected result, out_byte", 0, int'(out_data.out_byte));
        end else begin
          want = pending_results.pop_front();
          if (out_data.out_byte != want.out_byte)
            report("out_byte", int'(want.out_byte), int'(out_data.out_byte));
          if (out_data.last != want.last)
            report("last", int'(want.last), int'(out_data.last));
          if (out_data.found != want.found)
            report("found", int'(want.found), int'(out_data.found));
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the keyed tag field extractor: directed streams
// for the corner cases, then random well-formed and broken streams under
// many key and tag settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import kte_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int ITEM_TARGET    = 2025;
  localparam int PHASE_ITEMS    = 100;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;

  int          mismatches;
  int          outstanding;
  int          idle_cycles;
  int          items_sent;
  bit          quiet;
  bit          narrow;
  logic [7:0]  key_byte_q [KEY_BYTES];
  int          key_used;
  int          tag_goal;

  keyed_tag_field_extractor dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  kte_extract_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // no transfer on either channel for too long means the block hung
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("keyed_tag_field_extractor test failed");
        $finish;
      end
    end
  end

  // receiver: random stall before each result transfer
  initial begin
    int hold;
    out_stall = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0:       return CH_GT;
      1:       return CH_LT;
      2, 3:    return key_byte_q[$urandom_range(0, KEY_BYTES - 1)];
      4:       return narrow ? ($urandom_range(0, 1) ? 8'h61 : 8'h62)
                             : 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] filler_byte(input logic [7:0] excluded);
    logic [7:0] b;
    do b = noise_byte(); while (b == excluded);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit eos);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, eos};
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // lower valid, wait for every prediction to be met, then let the pipe empty
  task automatic settle(input int tail);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] len, input logic [7:0] tags);
    cfg_write <= 1'b1;
    cfg_index <= REG_KEY_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= REG_KEY_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= REG_KEY_LEN;
    cfg_data  <= {59'd0, len};
    @(posedge clk);
    cfg_index <= REG_TAG_CNT;
    cfg_data  <= {56'd0, tags};
    @(posedge clk);
    cfg_write <= 1'b0;
    for (int i = 0; i < KEY_BYTES; i++)
      key_byte_q[i] = (i < 8) ? lo[i*8 +: 8] : hi[(i-8)*8 +: 8];
    key_used = (len == 0) ? 1 : (len > KEY_BYTES) ? KEY_BYTES : int'(len);
    tag_goal = int'(tags);
  endtask

  // mostly key, tags, field and closing '<'; sometimes pure noise or cut short
  task automatic send_stream();
    logic [7:0] text [$];
    int         f;
    int         cut;
    int         tags_needed;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 30)) text.push_back(noise_byte());
    end else begin
      repeat ($urandom_range(0, 8)) text.push_back(noise_byte());
      for (int i = 0; i < key_used; i++) text.push_back(key_byte_q[i]);
      tags_needed = (tag_goal == 0) ? 3 : tag_goal;
      repeat (tags_needed) begin
        repeat ($urandom_range(0, 3)) text.push_back(filler_byte(CH_GT));
        text.push_back(CH_GT);
      end
      f = ($urandom_range(0, 11) == 0) ? $urandom_range(95, 105) : $urandom_range(1, 8);
      text.push_back(($urandom_range(0, 5) == 0) ? CH_LT : 8'($urandom_range(0, 255)));
      repeat (f - 1) text.push_back(filler_byte(CH_LT));
      text.push_back(CH_LT);
      repeat ($urandom_range(0, 3)) text.push_back(noise_byte());
      if ($urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, text.size());
        while (text.size() > cut) void'(text.pop_back());
      end
    end
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  initial begin
    logic [8:0]  directed_seq [25];
    logic [63:0] lo, hi;
    logic [4:0]  len_sel;
    logic [7:0]  tags_sel;
    int          phase_no;
    int          budget;

    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = REG_KEY_LOW;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    quiet      = 1'b0;
    narrow     = 1'b1;
    items_sent = 0;
    idle_cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // key "ab", second '>' opens the field; {eos, byte}
    directed_seq = '{
      // overlapping key, '<' as first field byte, bytes after success, quiet end
      9'h061, 9'h061, 9'h062, 9'h03E, 9'h078, 9'h03E, 9'h03C, 9'h071, 9'h03C,
      9'h07A, 9'h179,
      // key completed on the last byte
      9'h061, 9'h162,
      // end of stream replaces a field byte
      9'h061, 9'h062, 9'h03E, 9'h03E, 9'h0FF, 9'h100,
      // closing '<' on the last byte
      9'h061, 9'h062, 9'h03E, 9'h03E, 9'h06B, 9'h13C
    };
    set_config(64'h6261, 64'h0, 5'd2, 8'd2);
    foreach (directed_seq[i]) send_byte(directed_seq[i][7:0], directed_seq[i][8]);

    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      settle(8);
      narrow = $urandom_range(0, 1);
      for (int i = 0; i < 8; i++) begin
        lo[i*8 +: 8] = narrow ? ($urandom_range(0, 1) ? 8'h61 : 8'h62)
                              : 8'($urandom_range(0, 255));
        hi[i*8 +: 8] = narrow ? ($urandom_range(0, 1) ? 8'h61 : 8'h62)
                              : 8'($urandom_range(0, 255));
      end
      len_sel  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(1, 16));
      tags_sel = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(1, 4));
      case (phase_no)
        0: begin
          lo = '1; hi = '1; len_sel = 5'd16; tags_sel = 8'd1;
        end
        1: begin
          lo = '0; hi = '0; len_sel = 5'd0; tags_sel = 8'd0;
        end
        2: begin
          len_sel = 5'd31; tags_sel = 8'd255;
        end
        3: begin
          len_sel = 5'd17; tags_sel = 8'd3;
        end
        default: ;
      endcase
      set_config(lo, hi, len_sel, tags_sel);
      quiet  = (phase_no % 4 == 3);
      budget = items_sent + PHASE_ITEMS;
      while (items_sent < budget) send_stream();
      phase_no++;
    end

    settle(16);
    if (mismatches == 0) begin
      $display("keyed_tag_field_extractor test passed");
    end else begin
      $display("keyed_tag_field_extractor test failed");
    end
    $finish;
  end

endmodule
